// ===== rtl/gha_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the generational handle allocator.
package gha_pkg;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_DETACH  = 2'd2;
    localparam logic [1:0] ACT_LOOKUP  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_STALE = 2'd2;
    localparam logic [1:0] STATUS_OWNER = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } gha_state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic commit;
    } gha_cmd_t;

    typedef struct packed {
        logic clear_last;
    } gha_stat_t;

endpackage

// ===== rtl/gha_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: clearing pass, transfer sequencing, output valid.
module gha_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output gha_pkg::gha_cmd_t cmd,
    input  gha_pkg::gha_stat_t stat
);

    gha_pkg::gha_state_t state_reg;
    gha_pkg::gha_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gha_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        in_stall       = 1'b1;
        case (state_reg)
            gha_pkg::S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = gha_pkg::S_IDLE;
                end
            end
            gha_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = gha_pkg::S_EXEC;
                end
            end
            gha_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = gha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gha_pkg::S_CLEAR;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/gha_dp.sv =====
`timescale 1ns / 1ps
// Datapath: slot memories, free-list pointers, checks and result register.
module gha_dp
#(
    parameter int INDEX_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  gha_pkg::gha_cmd_t  cmd,
    output gha_pkg::gha_stat_t stat,
    input  logic [1:0]         action,
    input  logic [31:0]        handle,
    input  logic [31:0]        owner,
    output logic [1:0]         status,
    output logic [31:0]        handle_out,
    output logic [31:0]        owner_out
);

    localparam int SLOTS    = 1 << INDEX_BITS;
    localparam int GEN_BITS = 32 - INDEX_BITS;

    logic [GEN_BITS:0]   meta_mem [SLOTS];
    logic [INDEX_BITS-1:0] link_mem [SLOTS];
    logic [31:0]         owner_mem [SLOTS];

    logic [GEN_BITS:0]     meta_rd_reg;
    logic [INDEX_BITS-1:0] link_rd_reg;
    logic [31:0]           owner_rd_reg;

    logic [1:0]            act_reg;
    logic [31:0]           hnd_reg;
    logic [31:0]           own_reg;
    logic [INDEX_BITS-1:0] idx_reg;

    logic [INDEX_BITS-1:0] head_reg;
    logic [INDEX_BITS-1:0] head_next;
    logic [INDEX_BITS-1:0] tail_reg;
    logic [INDEX_BITS-1:0] tail_next;
    logic                  empty_reg;
    logic                  empty_next;
    logic [INDEX_BITS-1:0] clr_cnt_reg;

    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [31:0]           handle_out_reg;
    logic [31:0]           handle_out_next;
    logic [31:0]           owner_out_reg;
    logic [31:0]           owner_out_next;

    logic [INDEX_BITS-1:0] rd_idx;
    logic [GEN_BITS-1:0]   gen_rd;
    logic                  used_rd;
    logic [GEN_BITS-1:0]   gen_inc;
    logic                  hnd_ok;

    logic                  meta_we;
    logic [INDEX_BITS-1:0] meta_wa;
    logic [GEN_BITS:0]     meta_wd;
    logic                  link_we;
    logic [INDEX_BITS-1:0] link_wa;
    logic [INDEX_BITS-1:0] link_wd;
    logic                  owner_we;

    assign rd_idx  = (action == gha_pkg::ACT_ALLOC) ? head_reg : handle[INDEX_BITS-1:0];
    assign gen_rd  = meta_rd_reg[GEN_BITS:1];
    assign used_rd = meta_rd_reg[0];
    assign gen_inc = (gen_rd == {GEN_BITS{1'b1}}) ? GEN_BITS'(1) : GEN_BITS'(gen_rd + 1'b1);
    assign hnd_ok  = used_rd && (hnd_reg[31:INDEX_BITS] == gen_rd);

    assign stat.clear_last = (clr_cnt_reg == {INDEX_BITS{1'b1}});

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        empty_next      = empty_reg;
        status_next     = gha_pkg::STATUS_OK;
        handle_out_next = hnd_reg;
        owner_out_next  = '0;
        meta_we         = 1'b0;
        meta_wa         = idx_reg;
        meta_wd         = meta_rd_reg;
        link_we         = 1'b0;
        link_wa         = tail_reg;
        link_wd         = idx_reg;
        owner_we        = 1'b0;
        if (cmd.clear)
        begin
            meta_we = 1'b1;
            meta_wa = clr_cnt_reg;
            meta_wd = {GEN_BITS'(1), 1'b0};
            link_we = 1'b1;
            link_wa = clr_cnt_reg;
            link_wd = INDEX_BITS'(clr_cnt_reg + 1'b1);
        end
        else if (act_reg == gha_pkg::ACT_ALLOC)
        begin
            if (empty_reg)
            begin
                status_next     = gha_pkg::STATUS_FULL;
                handle_out_next = '0;
            end
            else
            begin
                if (idx_reg == tail_reg)
                begin
                    empty_next = 1'b1;
                end
                else
                begin
                    head_next = link_rd_reg;
                end
                meta_we         = cmd.commit;
                meta_wd         = {gen_rd, 1'b1};
                owner_we        = cmd.commit;
                handle_out_next = {gen_rd, idx_reg};
                owner_out_next  = own_reg;
            end
        end
        else if (!hnd_ok)
        begin
            status_next = gha_pkg::STATUS_STALE;
        end
        else
        begin
            owner_out_next = owner_rd_reg;
            if (act_reg == gha_pkg::ACT_DETACH && own_reg != owner_rd_reg)
            begin
                status_next = gha_pkg::STATUS_OWNER;
            end
            else if (act_reg inside {gha_pkg::ACT_RELEASE, gha_pkg::ACT_DETACH})
            begin
                meta_we   = cmd.commit;
                meta_wd   = {gen_inc, 1'b0};
                tail_next = idx_reg;
                if (empty_reg)
                begin
                    head_next  = idx_reg;
                    empty_next = 1'b0;
                end
                else
                begin
                    link_we = cmd.commit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= {INDEX_BITS{1'b1}};
            empty_reg   <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= INDEX_BITS'(clr_cnt_reg + 1'b1);
            end
            if (cmd.commit)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            hnd_reg <= handle;
            own_reg <= owner;
            idx_reg <= rd_idx;
        end
        if (cmd.commit)
        begin
            status_reg     <= status_next;
            handle_out_reg <= handle_out_next;
            owner_out_reg  <= owner_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_wa] <= meta_wd;
        end
        if (cmd.load)
        begin
            meta_rd_reg <= meta_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.load)
        begin
            link_rd_reg <= link_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[idx_reg] <= own_reg;
        end
        if (cmd.load)
        begin
            owner_rd_reg <= owner_mem[rd_idx];
        end
    end

    assign status     = status_reg;
    assign handle_out = handle_out_reg;
    assign owner_out  = owner_out_reg;

endmodule

// ===== rtl/generational_handle_allocator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the generational handle allocator.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid, in_stall | action, handle, owner
//  out     | output    | out_valid, out_stall| status, handle_out, owner_out
//
// Each transfer has two steps: the synchronous slot-memory read, then
// the read-modify-write of the slot and the free-list pointers.
// After reset a clearing pass over all 2^INDEX_BITS slots initializes generations and
// free-list links; in_stall stays high during it.
// A result waits in the output register; the next item may enter meanwhile and
// its commit holds only while that register is full and stalled.
module generational_handle_allocator_unit
#(
    parameter int INDEX_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] handle,
    input  logic [31:0] owner,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] handle_out,
    output logic [31:0] owner_out
);

    gha_pkg::gha_cmd_t  cmd;
    gha_pkg::gha_stat_t stat;

    gha_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    gha_dp
    #(
        .INDEX_BITS (INDEX_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (action),
        .handle     (handle),
        .owner      (owner),
        .status     (status),
        .handle_out (handle_out),
        .owner_out  (owner_out)
    );

endmodule

// ===== verif/generational_handle_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the generational handle allocator: scripted and random traffic.
module generational_handle_allocator_unit_tb;

    localparam int INDEX_BITS = 8;
    localparam int GEN_BITS   = 32 - INDEX_BITS;
    localparam int SLOTS      = 1 << INDEX_BITS;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] hdl;
        logic [31:0] own;
    } handle_result_t;

    typedef struct packed {
        logic [1:0]     act;
        logic [31:0]    hdl;
        logic [31:0]    own;
        logic [15:0]    reps;
        logic           typed;
        handle_result_t want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] handle;
    logic [31:0] owner;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [31:0] owner_out;

    // table mirror
    logic [GEN_BITS-1:0]   slot_gen   [SLOTS];
    bit                    slot_busy  [SLOTS];
    logic [INDEX_BITS-1:0] next_link  [SLOTS];
    logic [31:0]           slot_owner [SLOTS];
    logic [INDEX_BITS-1:0] list_head;
    logic [INDEX_BITS-1:0] list_tail;
    bit                    list_empty;

    handle_result_t pending_results [$];
    script_row_t    script [$];

    bit             next_typed;
    handle_result_t next_want;
    bit             idle_on;
    bit             stall_on;
    int             alloc_weight;
    int             hold_req;
    int             transfers_in;
    int             results_seen;
    int             mismatches;
    int             status_seen [4];

    generational_handle_allocator_unit #(
        .INDEX_BITS(INDEX_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .handle    (handle),
        .owner     (owner),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .handle_out(handle_out),
        .owner_out (owner_out)
    );

    always #6 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at result %0d: %s got %h, want %h",
                 results_seen, field, got, want);
    endtask

    task automatic apply_handle_op(input logic [1:0] act, input logic [31:0] hdl,
                                   input logic [31:0] own, output handle_result_t r);
        logic [INDEX_BITS-1:0] slot;
        logic [GEN_BITS-1:0]   hgen;
        r.st  = gha_pkg::STATUS_OK;
        r.hdl = hdl;
        r.own = '0;
        if (act == gha_pkg::ACT_ALLOC)
        begin
            if (list_empty)
            begin
                r.st  = gha_pkg::STATUS_FULL;
                r.hdl = '0;
            end
            else
            begin
                slot = list_head;
                if (slot == list_tail)
                    list_empty = 1'b1;
                else
                    list_head = next_link[slot];
                slot_busy[slot]  = 1'b1;
                slot_owner[slot] = own;
                r.hdl = {slot_gen[slot], slot};
                r.own = own;
            end
        end
        else
        begin
            slot = hdl[INDEX_BITS-1:0];
            hgen = hdl[31:INDEX_BITS];
            if (!slot_busy[slot] || hgen != slot_gen[slot])
                r.st = gha_pkg::STATUS_STALE;
            else
            begin
                r.own = slot_owner[slot];
                if (act == gha_pkg::ACT_DETACH && own != slot_owner[slot])
                    r.st = gha_pkg::STATUS_OWNER;
                else if (act != gha_pkg::ACT_LOOKUP)
                begin
                    // advance generation, skip zero on wrap
                    slot_gen[slot]  = (slot_gen[slot] == '1) ? GEN_BITS'(1)
                                                             : slot_gen[slot] + 1'b1;
                    slot_busy[slot] = 1'b0;
                    if (list_empty)
                    begin
                        list_head  = slot;
                        list_tail  = slot;
                        list_empty = 1'b0;
                    end
                    else
                    begin
                        next_link[list_tail] = slot;
                        list_tail = slot;
                    end
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : monitor
        handle_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, handle_out", handle_out, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (handle_out !== want.hdl)
                        report_mismatch("handle_out", handle_out, want.hdl);
                    if (owner_out !== want.own)
                        report_mismatch("owner_out", owner_out, want.own);
                    status_seen[want.st]++;
                end
            end
            if (in_valid && !in_stall)
            begin
                transfers_in++;
                apply_handle_op(action, handle, owner, want);
                if (next_typed)
                    want = next_want;
                pending_results.push_back(want);
            end
        end
    end

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        int stall_left;
        hold_seen  = 0;
        hold_left  = 0;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap(stall_on);
            end
        end
    end

    task automatic sender_gap();
        int gap;
        gap = pick_gap(idle_on);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic present(input logic [1:0] act, input logic [31:0] hdl,
                           input logic [31:0] own, input bit typed,
                           input handle_result_t want);
        action     <= act;
        handle     <= hdl;
        owner      <= own;
        in_valid   <= 1'b1;
        next_typed = typed;
        next_want  = want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_row(input logic [1:0] act, input logic [31:0] hdl,
                           input logic [31:0] own, input int reps, input bit typed,
                           input logic [1:0] st, input logic [31:0] h, input logic [31:0] o);
        script_row_t row;
        row.act   = act;
        row.hdl   = hdl;
        row.own   = own;
        row.reps  = 16'(reps);
        row.typed = typed;
        row.want  = {st, h, o};
        script.push_back(row);
    endtask

    function automatic logic [31:0] random_tag();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic find_busy_slot(output bit found, output logic [INDEX_BITS-1:0] slot);
        int start;
        found = 1'b0;
        slot  = '0;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS && !found; k++)
        begin
            if (slot_busy[(start + k) % SLOTS])
            begin
                found = 1'b1;
                slot  = INDEX_BITS'((start + k) % SLOTS);
            end
        end
    endtask

    task automatic pick_random_op(output logic [1:0] act, output logic [31:0] hdl,
                                  output logic [31:0] own);
        int                    r;
        bit                    found;
        logic [INDEX_BITS-1:0] slot;
        logic [GEN_BITS-1:0]   g;
        act = gha_pkg::ACT_ALLOC;
        hdl = $urandom;
        own = random_tag();
        if ($urandom_range(0, 99) < alloc_weight)
            return;
        find_busy_slot(found, slot);
        r = $urandom_range(0, 99);
        if (!found || r < 12)
            act = 2'($urandom_range(1, 3));
        else if (r < 24)
        begin
            act = 2'($urandom_range(1, 3));
            case ($urandom_range(0, 3))
                0: g = slot_gen[slot] - 1'b1;
                1: g = slot_gen[slot] + 1'b1;
                2: g = '0;
                default:
                begin
                    slot = INDEX_BITS'($urandom_range(0, SLOTS - 1));
                    g    = slot_gen[slot];
                end
            endcase
            hdl = {g, slot};
        end
        else
        begin
            hdl = {slot_gen[slot], slot};
            if (r < 50)
                act = gha_pkg::ACT_RELEASE;
            else if (r < 70)
            begin
                act = gha_pkg::ACT_DETACH;
                own = slot_owner[slot];
            end
            else if (r < 78)
            begin
                act = gha_pkg::ACT_DETACH;
                own = slot_owner[slot] ^ (32'd1 << $urandom_range(0, 31));
            end
            else
                act = gha_pkg::ACT_LOOKUP;
        end
    endtask

    initial
    begin
        script_row_t    row;
        logic [1:0]     act;
        logic [31:0]    hdl;
        logic [31:0]    own;
        handle_result_t none;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = gha_pkg::ACT_ALLOC;
        handle       = '0;
        owner        = '0;
        next_typed   = 1'b0;
        next_want    = '0;
        none         = '0;
        idle_on      = 1'b0;
        stall_on     = 1'b0;
        alloc_weight = 50;
        hold_req     = 0;
        transfers_in = 0;
        results_seen = 0;
        mismatches   = 0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_gen[i]   = GEN_BITS'(1);
            slot_busy[i]  = 1'b0;
            next_link[i]  = INDEX_BITS'(i + 1);
            slot_owner[i] = '0;
        end
        list_head  = '0;
        list_tail  = INDEX_BITS'(SLOTS - 1);
        list_empty = 1'b0;

        add_row(gha_pkg::ACT_LOOKUP,  32'h0000_0100, '0,  1, 1,
                gha_pkg::STATUS_STALE, 32'h0000_0100, '0);
        add_row(gha_pkg::ACT_ALLOC,   '1,            '1,  1, 1,
                gha_pkg::STATUS_OK,    32'h0000_0100, '1);
        add_row(gha_pkg::ACT_ALLOC,   '0,            '0,  1, 1,
                gha_pkg::STATUS_OK,    32'h0000_0101, '0);
        add_row(gha_pkg::ACT_LOOKUP,  32'h0000_0100, '0,  1, 1,
                gha_pkg::STATUS_OK,    32'h0000_0100, '1);
        add_row(gha_pkg::ACT_LOOKUP,  32'h0000_0000, '0,  1, 1,
                gha_pkg::STATUS_STALE, 32'h0000_0000, '0);
        add_row(gha_pkg::ACT_DETACH,  32'h0000_0100, 32'h1234_5678, 1, 1,
                gha_pkg::STATUS_OWNER, 32'h0000_0100, '1);
        add_row(gha_pkg::ACT_DETACH,  32'h0000_0100, '1,  1, 1,
                gha_pkg::STATUS_OK,    32'h0000_0100, '1);
        add_row(gha_pkg::ACT_RELEASE, 32'h0000_0100, '0,  1, 1,
                gha_pkg::STATUS_STALE, 32'h0000_0100, '0);
        add_row(gha_pkg::ACT_RELEASE, 32'h0000_0101, '1,  1, 1,
                gha_pkg::STATUS_OK,    32'h0000_0101, '0);
        add_row(gha_pkg::ACT_LOOKUP,  '1,            '1,  1, 1,
                gha_pkg::STATUS_STALE, '1,            '0);
        add_row(gha_pkg::ACT_DETACH,  32'hFFFF_FF01, '0,  1, 1,
                gha_pkg::STATUS_STALE, 32'hFFFF_FF01, '0);
        // fill every slot, then run past full
        add_row(gha_pkg::ACT_ALLOC,   '0, 32'hA5A5_A5A5, SLOTS + 4, 0,
                gha_pkg::STATUS_OK, '0, '0);
        add_row(gha_pkg::ACT_ALLOC,   32'h0000_0042, 32'h0000_0007, 1, 1,
                gha_pkg::STATUS_FULL, '0, '0);
        add_row(gha_pkg::ACT_RELEASE, 32'h0000_01FF, '0,  1, 1,
                gha_pkg::STATUS_OK,    32'h0000_01FF, 32'hA5A5_A5A5);
        add_row(gha_pkg::ACT_LOOKUP,  32'h0000_01FF, '0,  1, 1,
                gha_pkg::STATUS_STALE, 32'h0000_01FF, '0);
        add_row(gha_pkg::ACT_ALLOC,   '0, 32'h0000_0001,  1, 0,
                gha_pkg::STATUS_OK,    '0, '0);
        add_row(gha_pkg::ACT_LOOKUP,  32'h0000_02FF, '0,  1, 0,
                gha_pkg::STATUS_OK,    '0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n    = 1'b1;
        idle_on  = 1'b1;
        stall_on = 1'b1;

        foreach (script[i])
        begin
            row = script[i];
            repeat (row.reps)
            begin
                sender_gap();
                present(row.act, row.hdl, row.own, row.typed, row.want);
            end
        end
        drain_results();

        for (int phase = 0; phase < 16; phase++)
        begin
            case ($urandom_range(0, 3))
                0: alloc_weight = 10;
                1: alloc_weight = 30;
                2: alloc_weight = 50;
                default: alloc_weight = 85;
            endcase
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            if (phase == 2)
            begin
                idle_on = 1'b0;
                hold_req++;
            end
            repeat (100)
            begin
                sender_gap();
                pick_random_op(act, hdl, own);
                present(act, hdl, own, 1'b0, none);
            end
            if (phase % 4 == 3)
                drain_results();
        end

        drain_results();
        repeat (10) @(negedge clk);
        $display("summary: %0d transfers in, %0d results, %0d mismatches",
                 transfers_in, results_seen, mismatches);
        $display("summary: ok %0d, table full %0d, stale %0d, owner mismatch %0d",
                 status_seen[gha_pkg::STATUS_OK], status_seen[gha_pkg::STATUS_FULL],
                 status_seen[gha_pkg::STATUS_STALE], status_seen[gha_pkg::STATUS_OWNER]);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
